// ===== src/mtep_pkg.sv =====
// Shared types and constants for the MIDI track event parser.
// No dependencies; imported by all modules but the checker.
package mtep_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = 4;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRUM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_B = 2'd2;

  localparam logic [CFG_W-1:0] DRUM_RESET   = 5'd9;
  localparam logic [CFG_W-1:0] IGNORE_RESET = 5'd16;

  // status and meta codes
  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO       = 8'h51;
  localparam logic [3:0] MSG_NOTE_OFF     = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON      = 4'h9;
  localparam logic [3:0] MSG_PROGRAM      = 4'hC;
  localparam logic [3:0] MSG_CHAN_PRESS   = 4'hD;

  localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
  localparam logic [31:0] TEMPO_LEN     = 32'd3;

  typedef logic [NUM_CHANNELS-1:0][7:0] note_array_t;

  typedef struct packed {
    logic [31:0]     tick_count;
    logic            melody_valid;
    logic [CH_W-1:0] melody_channel;
    logic [7:0]      melody_note;
    logic [23:0]     tempo_us;
    logic            end_of_track;
  } result_t;

endpackage

// ===== src/mtep_melody.sv =====
// Melody pick: lowest active channel that is not excluded.
// Depends on mtep_pkg.
module mtep_melody (
  input  logic [mtep_pkg::NUM_CHANNELS-1:0] active,
  input  mtep_pkg::note_array_t             notes,
  input  logic [mtep_pkg::CFG_W-1:0]        perc_channel,
  input  logic [mtep_pkg::CFG_W-1:0]        ignore_channel_a,
  input  logic [mtep_pkg::CFG_W-1:0]        ignore_channel_b,
  output logic                              melody_valid,
  output logic [mtep_pkg::CH_W-1:0]         melody_channel,
  output logic [7:0]                        melody_note
);
  import mtep_pkg::*;

  logic [NUM_CHANNELS-1:0] eligible;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      eligible[i] = active[i]
                 && (CFG_W'(i) != perc_channel)
                 && (CFG_W'(i) != ignore_channel_a)
                 && (CFG_W'(i) != ignore_channel_b);
    end
  end

  // priority chain, lowest index wins
  always_comb begin
    melody_valid   = 1'b0;
    melody_channel = '0;
    melody_note    = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        melody_valid   = 1'b1;
        melody_channel = CH_W'(i);
        melody_note    = notes[i];
      end
    end
  end

endmodule

// ===== src/mtep_parser.sv =====
// Per-byte track parser: delta/length decode, status tracking, tempo capture
// and the active-note table. Depends on mtep_pkg and mtep_melody.
module mtep_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 data_byte,
  input  logic                       first_of_song,
  input  logic                       last_byte,
  input  logic [mtep_pkg::CFG_W-1:0] perc_channel,
  input  logic [mtep_pkg::CFG_W-1:0] ignore_channel_a,
  input  logic [mtep_pkg::CFG_W-1:0] ignore_channel_b,
  output logic                       res_valid,
  output mtep_pkg::result_t          res
);
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
    PH_META_LEN, PH_META_BODY, PH_SYX_LEN, PH_SYX_BODY
  } phase_t;

  phase_t                  phase;
  logic [31:0]             acc;
  logic [31:0]             rem_len;
  logic [7:0]              meta_kind;
  logic [7:0]              last_status;
  logic [7:0]              current_status;
  logic [7:0]              first_data;
  logic [23:0]             tempo;
  logic [23:0]             tempo_cap;
  logic [NUM_CHANNELS-1:0] active;
  note_array_t             notes;

  // state as seen by this byte (song restart applied first)
  phase_t                  phase_e;
  logic [31:0]             acc_e, rem_e;
  logic [7:0]              mk_e, rs_e, cs_e, fd_e;
  logic [23:0]             tempo_e, cap_e;
  logic [NUM_CHANNELS-1:0] active_e;

  phase_t                  phase_next;
  logic [31:0]             acc_next, rem_len_next, vlq;
  logic [7:0]              meta_kind_next, last_status_next;
  logic [7:0]              current_status_next, first_data_next;
  logic [23:0]             tempo_next, tempo_cap_next;
  logic [NUM_CHANNELS-1:0] active_next;
  note_array_t             notes_next;

  logic                    in_delta, delta_done;
  logic [3:0]              msg_type, rs_type;
  logic [CH_W-1:0]         msg_ch;
  logic [31:0]             res_delta;
  logic                    mel_valid;
  logic [CH_W-1:0]         mel_ch;
  logic [7:0]              mel_note;

  always_comb begin
    phase_e  = first_of_song ? PH_DELTA : phase;
    acc_e    = first_of_song ? '0 : acc;
    rem_e    = first_of_song ? '0 : rem_len;
    mk_e     = first_of_song ? '0 : meta_kind;
    rs_e     = first_of_song ? '0 : last_status;
    cs_e     = first_of_song ? '0 : current_status;
    fd_e     = first_of_song ? '0 : first_data;
    tempo_e  = first_of_song ? TEMPO_DEFAULT : tempo;
    cap_e    = first_of_song ? '0 : tempo_cap;
    active_e = first_of_song ? '0 : active;
  end

  assign vlq      = {acc_e[24:0], data_byte[6:0]};
  assign msg_type = cs_e[7:4];
  assign msg_ch   = cs_e[3:0];
  assign rs_type  = rs_e[7:4];

  always_comb begin
    phase_next          = phase_e;
    acc_next            = acc_e;
    rem_len_next        = rem_e;
    meta_kind_next      = mk_e;
    last_status_next    = rs_e;
    current_status_next = cs_e;
    first_data_next     = fd_e;
    tempo_next          = tempo_e;
    tempo_cap_next      = cap_e;
    active_next         = active_e;
    notes_next          = notes;
    in_delta            = 1'b0;
    delta_done          = 1'b0;
    res_delta           = '0;

    case (phase_e)
      PH_DELTA: begin
        in_delta = 1'b1;
        acc_next = vlq;
        if (!data_byte[7]) begin
          delta_done = 1'b1;
          phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (data_byte == STATUS_META) begin
          phase_next = PH_META_TYPE;
        end else if (data_byte == STATUS_SYSEX || data_byte == STATUS_SYSEX_ESC) begin
          acc_next   = '0;
          phase_next = PH_SYX_LEN;
        end else if (data_byte[7]) begin
          last_status_next    = data_byte;
          current_status_next = data_byte;
          phase_next          = PH_DATA1;
        end else begin
          // running status
          current_status_next = rs_e;
          first_data_next     = data_byte;
          phase_next = (rs_type == MSG_PROGRAM || rs_type == MSG_CHAN_PRESS)
                     ? PH_DELTA : PH_DATA2;
        end
      end
      PH_DATA1: begin
        first_data_next = data_byte;
        phase_next = (msg_type == MSG_PROGRAM || msg_type == MSG_CHAN_PRESS)
                   ? PH_DELTA : PH_DATA2;
      end
      PH_DATA2: begin
        if (msg_type == MSG_NOTE_ON && data_byte != 8'd0) begin
          active_next[msg_ch] = 1'b1;
          notes_next[msg_ch]  = fd_e;
        end else if ((msg_type == MSG_NOTE_ON || msg_type == MSG_NOTE_OFF)
                     && active_e[msg_ch] && notes[msg_ch] == fd_e) begin
          active_next[msg_ch] = 1'b0;
        end
        phase_next = PH_DELTA;
      end
      PH_META_TYPE: begin
        meta_kind_next = data_byte;
        acc_next       = '0;
        phase_next     = PH_META_LEN;
      end
      PH_META_LEN, PH_SYX_LEN: begin
        acc_next = vlq;
        if (!data_byte[7]) begin
          rem_len_next = vlq;
          if (phase_e == PH_META_LEN) begin
            if (mk_e == META_TEMPO && vlq != TEMPO_LEN) meta_kind_next = '0;
            tempo_cap_next = '0;
            phase_next     = PH_META_BODY;
          end else begin
            phase_next = PH_SYX_BODY;
          end
          if (vlq == 32'd0) phase_next = PH_DELTA;
        end
      end
      PH_META_BODY: begin
        if (mk_e == META_TEMPO) tempo_cap_next = {cap_e[15:0], data_byte};
        rem_len_next = rem_e - 32'd1;
        if (rem_len_next == 32'd0) begin
          if (mk_e == META_TEMPO) tempo_next = tempo_cap_next;
          phase_next = PH_DELTA;
        end
      end
      PH_SYX_BODY: begin
        rem_len_next = rem_e - 32'd1;
        if (rem_len_next == 32'd0) phase_next = PH_DELTA;
      end
      default: begin
        phase_next = PH_DELTA;
      end
    endcase

    if (phase_next == PH_DELTA && !in_delta && !last_byte) acc_next = '0;

    if (last_byte) begin
      res_delta           = in_delta ? acc_next : 32'd0;
      phase_next          = PH_DELTA;
      acc_next            = '0;
      last_status_next    = '0;
      current_status_next = '0;
    end else if (delta_done) begin
      res_delta = acc_next;
      acc_next  = '0;
    end
  end

  mtep_melody u_melody (
    .active           (active_next),
    .notes            (notes_next),
    .perc_channel     (perc_channel),
    .ignore_channel_a (ignore_channel_a),
    .ignore_channel_b (ignore_channel_b),
    .melody_valid     (mel_valid),
    .melody_channel   (mel_ch),
    .melody_note      (mel_note)
  );

  assign res_valid = accept && (last_byte || delta_done);

  always_comb begin
    res.tick_count     = res_delta;
    res.melody_valid   = mel_valid;
    res.melody_channel = mel_ch;
    res.melody_note    = mel_note;
    res.tempo_us       = tempo_next;
    res.end_of_track   = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      acc            <= '0;
      rem_len        <= '0;
      meta_kind      <= '0;
      last_status    <= '0;
      current_status <= '0;
      first_data     <= '0;
      tempo          <= TEMPO_DEFAULT;
      tempo_cap      <= '0;
      active         <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      acc            <= acc_next;
      rem_len        <= rem_len_next;
      meta_kind      <= meta_kind_next;
      last_status    <= last_status_next;
      current_status <= current_status_next;
      first_data     <= first_data_next;
      tempo          <= tempo_next;
      tempo_cap      <= tempo_cap_next;
      active         <= active_next;
      notes          <= notes_next;
    end
  end

endmodule

// ===== src/mtep_outbuf.sv =====
// Result register with one skid slot; stalls the input only when both hold.
// Depends on mtep_pkg.
module mtep_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  mtep_pkg::result_t res,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mtep_pkg::result_t out_word
);
  import mtep_pkg::*;

  logic    skid_valid;
  result_t skid_word;
  logic    out_take;

  assign in_stall = skid_valid;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // input is stalled here, so res_valid is low
      if (out_take) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_take) begin
        out_word  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/midi_track_event_parser_core.sv =====
// MIDI track event parser, top level: config registers, parser, output buffer.
// Depends on mtep_pkg, mtep_parser, mtep_outbuf.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one byte of track chunk data per
//   word, with first_of_song (restart song state before this byte) and
//   last_byte (close the track). Output channel (out_valid/out_stall) carries
//   one result word per byte that completes a delta time or is a last byte.
//   A result word enters the result register, or the skid slot if that holds
//   an untaken word. Throughput: one byte per cycle while in_stall is low, set
//   by the parser state update and the 16-entry melody priority select.
//   Stall: the result register plus one skid slot let the input keep flowing
//   while a result waits; in_stall rises only when both are full.
//   Reset (rst, synchronous): parser idle in delta-time decode, tempo 500000,
//   note table empty, drum channel 9, ignore channels disabled (16).
//   Config: cfg_we writes cfg_data into register cfg_index (0 drum, 1 and 2
//   ignore channels); write only while the block is idle.
module midi_track_event_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mtep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtep_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           first_of_song,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    tick_count,
  output logic                           melody_valid,
  output logic [mtep_pkg::CH_W-1:0]      melody_channel,
  output logic [7:0]                     melody_note,
  output logic [23:0]                    tempo_us,
  output logic                           end_of_track
);
  import mtep_pkg::*;

  logic [CFG_W-1:0] perc_channel;
  logic [CFG_W-1:0] ignore_channel_a;
  logic [CFG_W-1:0] ignore_channel_b;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_word;

  // config registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      perc_channel     <= DRUM_RESET;
      ignore_channel_a <= IGNORE_RESET;
      ignore_channel_b <= IGNORE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRUM:     perc_channel     <= cfg_data;
        CFG_IGNORE_A: ignore_channel_a <= cfg_data;
        CFG_IGNORE_B: ignore_channel_b <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid && !in_stall;

  mtep_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .data_byte        (data_byte),
    .first_of_song    (first_of_song),
    .last_byte        (last_byte),
    .perc_channel     (perc_channel),
    .ignore_channel_a (ignore_channel_a),
    .ignore_channel_b (ignore_channel_b),
    .res_valid        (res_valid),
    .res              (res)
  );

  mtep_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign tick_count     = out_word.tick_count;
  assign melody_valid   = out_word.melody_valid;
  assign melody_channel = out_word.melody_channel;
  assign melody_note    = out_word.melody_note;
  assign tempo_us       = out_word.tempo_us;
  assign end_of_track   = out_word.end_of_track;

endmodule

// ===== src/mtep_checker.sv =====
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on midi_track_event_parser_core's port list only.
module mtep_port_props (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] tick_count,
  input logic        melody_valid,
  input logic [3:0]  melody_channel,
  input logic [7:0]  melody_note
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(tick_count))
    else $error("result changed while stalled");

  // input backpressure only follows a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("in_stall without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

  a_no_melody_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !melody_valid |-> melody_channel == 4'd0 && melody_note == 8'd0)
    else $error("melody fields set without melody_valid");

endmodule

bind midi_track_event_parser_core mtep_port_props u_mtep_port_props (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .tick_count     (tick_count),
  .melody_valid   (melody_valid),
  .melody_channel (melody_channel),
  .melody_note    (melody_note)
);
